// File: sv/bdq_pkg.sv
// Shared constants for the bounded deque: field widths, operation codes
// and status codes. No dependencies.
package bdq_pkg;

    // Field widths of the input and result beats
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam int DEFAULT_CAPACITY = 16;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

endpackage

// File: sv/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/bounded_deque_with_indexed_removal_unit.sv
// Top level of the bounded deque with indexed removal.
// Depends on bdq_pkg and bdq_ram.
//
// Bounded double-ended queue of CAPACITY signed 32-bit entries held in a ring
// buffer RAM. Each input beat carries one operation (push front/back, pop
// front/back, remove at index, dump); each result beat carries a status, an
// entry, the occupancy after the operation and a last flag. The block takes
// one input beat at a time: in_stall is high from acceptance until the
// sequencer has handed its final result to the output register, which then
// holds it while the downstream side stalls. All slot addresses come from one
// shared ring-index adder, and all entry traffic goes through the single
// read and single write port of the RAM. A removal closes the gap by reading
// each later entry and writing it one slot nearer the front; a dump reads
// each entry in turn and hands it to the output register before reading the
// next.
// Occupancy is reported in 5 bits.
module bounded_deque_with_indexed_removal_unit
    import bdq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VALUE_W-1:0]  entry,
    output logic [OCC_W-1:0]           occupancy,
    output logic                       last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_DATA,
        S_RM_RD,
        S_RM_NEXT,
        S_RM_WR,
        S_DP_RD,
        S_DP_DATA,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [AW-1:0]       front_reg, front_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       i_reg, i_next;
    logic                first_reg, first_next;
    logic                more_reg, more_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_entry_reg, res_entry_next;
    logic                res_last_reg, res_last_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [VALUE_W-1:0]  out_entry_reg, out_entry_next;
    logic [OCC_W-1:0]    out_occ_reg, out_occ_next;
    logic                out_last_reg, out_last_next;

    // RAM port signals
    logic               wr_en, rd_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [VALUE_W-1:0] wr_data, rd_data;

    // Shared ring-index unit: slot = (front + idx) mod CAPACITY
    logic [AW-1:0] idx;
    logic [AW:0]   slot_sum;
    logic [AW:0]   slot_wrap;
    logic [AW-1:0] slot;

    assign slot_sum  = {1'b0, front_reg} + {1'b0, idx};
    assign slot_wrap = (slot_sum >= (AW + 1)'(CAPACITY)) ? slot_sum - (AW + 1)'(CAPACITY)
                                                         : slot_sum;
    assign slot      = slot_wrap[AW-1:0];

    // Width helpers
    logic [CW+POS_W-1:0] pos_cmp, count_cmp;
    logic [AW+POS_W-1:0] pos_ext;
    logic [OCC_W+CW-1:0] occ_ext;
    logic [CW:0]         i_plus1;
    logic [CW-1:0]       count_m1;
    logic                is_empty, is_full, more_shift, dump_last;
    logic                out_free, accept;

    assign pos_cmp    = {{CW{1'b0}}, pos_reg};
    assign count_cmp  = {{POS_W{1'b0}}, count_reg};
    assign pos_ext    = {{AW{1'b0}}, pos_reg};
    assign occ_ext    = {{OCC_W{1'b0}}, count_reg};
    assign i_plus1    = {{(CW + 1 - AW){1'b0}}, i_reg} + (CW + 1)'(1);
    assign count_m1   = count_reg - CW'(1);
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == CW'(CAPACITY));
    assign more_shift = (i_plus1 < {1'b0, count_reg});
    assign dump_last  = (i_plus1 == {1'b0, count_reg});

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Ring index selection per step
    always_comb
    begin
        idx = '0;
        case (state_reg)
            S_DECODE:
            begin
                case (mode_reg)
                    MODE_PUSH_FRONT: idx = AW'(CAPACITY - 1);
                    MODE_PUSH_BACK:  idx = count_reg[AW-1:0];
                    MODE_POP_BACK:   idx = count_m1[AW-1:0];
                    default:         idx = '0;
                endcase
            end
            S_POP_DATA: idx = AW'(1);
            S_RM_RD:    idx = i_reg;
            S_RM_NEXT:  idx = i_plus1[AW-1:0];
            S_RM_WR:    idx = i_reg;
            S_DP_RD:    idx = i_reg;
            default:    idx = '0;
        endcase
    end

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        i_next          = i_reg;
        first_next      = first_reg;
        more_next       = more_reg;
        res_status_next = res_status_reg;
        res_entry_next  = res_entry_reg;
        res_last_next   = res_last_reg;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_addr         = slot;
        wr_data         = value_reg;
        rd_en           = 1'b0;
        rd_addr         = slot;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = mode;
                    value_next = value;
                    pos_next   = position;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                res_status_next = STATUS_OK;
                res_entry_next  = '0;
                res_last_next   = 1'b1;
                more_next       = 1'b0;
                state_next      = S_EMIT;
                case (mode_reg)
                    MODE_PUSH_FRONT, MODE_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                            if (mode_reg == MODE_PUSH_FRONT)
                            begin
                                front_next = slot;
                            end
                        end
                    end
                    MODE_POP_FRONT, MODE_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            state_next = S_POP_DATA;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else if (pos_cmp >= count_cmp)
                        begin
                            res_status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            i_next     = pos_ext[AW-1:0];
                            first_next = 1'b1;
                            state_next = S_RM_RD;
                        end
                    end
                    MODE_DUMP:
                    begin
                        if (is_empty)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            i_next     = '0;
                            state_next = S_DP_RD;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end

            // Popped value arrives; advance front for a front pop
            S_POP_DATA:
            begin
                res_entry_next = rd_data;
                count_next     = count_m1;
                if (mode_reg == MODE_POP_FRONT)
                begin
                    front_next = slot;
                end
                state_next = S_EMIT;
            end

            // Read the entry being removed
            S_RM_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_RM_NEXT;
            end

            // Capture removed value once, then fetch the next entry to shift
            S_RM_NEXT:
            begin
                if (first_reg)
                begin
                    res_entry_next = rd_data;
                    first_next     = 1'b0;
                end
                if (more_shift)
                begin
                    rd_en      = 1'b1;
                    state_next = S_RM_WR;
                end
                else
                begin
                    count_next = count_m1;
                    state_next = S_EMIT;
                end
            end

            // Close the gap: entry i takes entry i+1
            S_RM_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                i_next     = i_plus1[AW-1:0];
                state_next = S_RM_NEXT;
            end

            S_DP_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DP_DATA;
            end

            S_DP_DATA:
            begin
                res_entry_next  = rd_data;
                res_status_next = STATUS_OK;
                res_last_next   = dump_last;
                more_next       = !dump_last;
                state_next      = S_EMIT;
            end

            // Hand the result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_entry_next  = res_entry_reg;
                    out_occ_next    = occ_ext[OCC_W-1:0];
                    out_last_next   = res_last_reg;
                    if (more_reg)
                    begin
                        i_next     = i_plus1[AW-1:0];
                        state_next = S_DP_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            front_reg      <= '0;
            count_reg      <= '0;
            i_reg          <= '0;
            first_reg      <= 1'b0;
            more_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= '0;
            value_reg      <= '0;
            pos_reg        <= '0;
            res_status_reg <= '0;
            res_entry_reg  <= '0;
            res_last_reg   <= 1'b0;
            out_status_reg <= '0;
            out_entry_reg  <= '0;
            out_occ_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            front_reg      <= front_next;
            count_reg      <= count_next;
            i_reg          <= i_next;
            first_reg      <= first_next;
            more_reg       <= more_next;
            out_valid_reg  <= out_valid_next;
            mode_reg       <= mode_next;
            value_reg      <= value_next;
            pos_reg        <= pos_next;
            res_status_reg <= res_status_next;
            res_entry_reg  <= res_entry_next;
            res_last_reg   <= res_last_next;
            out_status_reg <= out_status_next;
            out_entry_reg  <= out_entry_next;
            out_occ_reg    <= out_occ_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Entry storage
    bdq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_entries (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign entry     = out_entry_reg;
    assign occupancy = out_occ_reg;
    assign last      = out_last_reg;

endmodule
